>>> rtl/core/fmbq_pkg.sv
// ----------------------------------------------------------------------------
// fmbq_pkg
// Shared types, constants and ring index helpers for the front/middle/back
// queue: operation and status codes, the per-operation access plan and the
// sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package fmbq_pkg;

  // Queue sizing
  localparam int CAPACITY   = 1024;
  localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
  localparam int ADDR_W     = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int HCNT_W     = $clog2(HALF_DEPTH + 1);
  localparam int TOT_W      = HCNT_W + 1;

  // Field widths
  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int COUNT_W = 11;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [HCNT_W-1:0] hcnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT  = 3'd0,
    OP_PUSH_MIDDLE = 3'd1,
    OP_PUSH_BACK   = 3'd2,
    OP_POP_FRONT   = 3'd3,
    OP_POP_MIDDLE  = 3'd4,
    OP_POP_BACK    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Which half supplies the popped element
  typedef enum logic [1:0] {
    POP_NONE  = 2'd0,
    POP_FRONT = 2'd1,
    POP_BACK  = 2'd2
  } pop_src_t;

  // Sequencer states
  typedef enum logic {
    S_IDLE  = 1'b0,
    S_WRITE = 1'b1
  } state_t;

  // Memory accesses of one operation: reads in the accept cycle, writes in
  // the write-back state. A moved element comes from the other half's read.
  typedef struct packed {
    logic     f_rd;
    addr_t    f_rd_addr;
    logic     b_rd;
    addr_t    b_rd_addr;
    pop_src_t pop_src;
    logic     f_wr;
    addr_t    f_wr_addr;
    logic     f_wr_moved;
    logic     b_wr;
    addr_t    b_wr_addr;
    logic     b_wr_moved;
    status_t  status;
    logic [COUNT_W-1:0] count;
  } plan_t;

  // Ring position start + k, wrapped once
  function automatic addr_t ring_idx(input addr_t start, input hcnt_t k);
    logic [TOT_W:0] sum;
    begin
      sum = (TOT_W+1)'(start) + (TOT_W+1)'(k);
      if (sum >= (TOT_W+1)'(HALF_DEPTH)) begin
        sum = sum - (TOT_W+1)'(HALF_DEPTH);
      end
      return ADDR_W'(sum);
    end
  endfunction

  // Ring position start - 1, wrapped
  function automatic addr_t ring_dec(input addr_t start);
    begin
      if (start == '0) begin
        return ADDR_W'(HALF_DEPTH - 1);
      end
      return start - ADDR_W'(1);
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/fmbq_ram.sv
// ----------------------------------------------------------------------------
// fmbq_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module fmbq_ram #(
  parameter  int DEPTH = 512,
  parameter  int WIDTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/fmbq_ctrl.sv
// ----------------------------------------------------------------------------
// fmbq_ctrl
// Ring pointers and counts of both halves. Decodes an operation against the
// current pointers into a plan of memory reads and writes, and advances the
// pointers when the transaction is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module fmbq_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        take,
  input  wire logic [fmbq_pkg::OP_W-1:0]   operation,
  output fmbq_pkg::plan_t                  plan
);

  fmbq_pkg::addr_t front_start, front_start_next;
  fmbq_pkg::addr_t back_start,  back_start_next;
  fmbq_pkg::hcnt_t front_count, front_count_next;
  fmbq_pkg::hcnt_t back_count,  back_count_next;

  logic [fmbq_pkg::TOT_W-1:0] total;
  logic [fmbq_pkg::TOT_W-1:0] total_next;
  logic                       front_heavy;
  fmbq_pkg::addr_t            f_last, f_tail, f_prev, f_next;
  fmbq_pkg::addr_t            b_last, b_tail, b_prev, b_next;

  // Ring positions of the current state
  always_comb begin
    total       = fmbq_pkg::TOT_W'(front_count) + fmbq_pkg::TOT_W'(back_count);
    front_heavy = front_count > back_count;
    f_last      = fmbq_pkg::ring_idx(front_start, front_count - fmbq_pkg::HCNT_W'(1));
    f_tail      = fmbq_pkg::ring_idx(front_start, front_count);
    f_prev      = fmbq_pkg::ring_dec(front_start);
    f_next      = fmbq_pkg::ring_idx(front_start, fmbq_pkg::HCNT_W'(1));
    b_last      = fmbq_pkg::ring_idx(back_start, back_count - fmbq_pkg::HCNT_W'(1));
    b_tail      = fmbq_pkg::ring_idx(back_start, back_count);
    b_prev      = fmbq_pkg::ring_dec(back_start);
    b_next      = fmbq_pkg::ring_idx(back_start, fmbq_pkg::HCNT_W'(1));
  end

  // Decode the operation into accesses and next pointers
  always_comb begin
    plan             = '0;
    plan.pop_src     = fmbq_pkg::POP_NONE;
    plan.status      = fmbq_pkg::ST_OK;
    front_start_next = front_start;
    back_start_next  = back_start;
    front_count_next = front_count;
    back_count_next  = back_count;

    unique case (operation) inside
      fmbq_pkg::OP_PUSH_FRONT,
      fmbq_pkg::OP_PUSH_MIDDLE,
      fmbq_pkg::OP_PUSH_BACK: begin
        if (total >= fmbq_pkg::TOT_W'(fmbq_pkg::CAPACITY)) begin
          plan.status = fmbq_pkg::ST_FULL;
        end else if (operation == fmbq_pkg::OP_PUSH_BACK) begin
          if (!front_heavy && back_count != '0) begin
            // shift the first back element to the front tail, append behind
            plan.b_rd        = 1'b1;
            plan.b_rd_addr   = back_start;
            plan.f_wr        = 1'b1;
            plan.f_wr_addr   = f_tail;
            plan.f_wr_moved  = 1'b1;
            plan.b_wr        = 1'b1;
            plan.b_wr_addr   = b_tail;
            back_start_next  = b_next;
            front_count_next = front_count + fmbq_pkg::HCNT_W'(1);
          end else if (!front_heavy) begin
            plan.f_wr        = 1'b1;
            plan.f_wr_addr   = f_tail;
            front_count_next = front_count + fmbq_pkg::HCNT_W'(1);
          end else begin
            plan.b_wr        = 1'b1;
            plan.b_wr_addr   = b_tail;
            back_count_next  = back_count + fmbq_pkg::HCNT_W'(1);
          end
        end else begin
          // move the last front element over when the front is heavy
          if (front_heavy) begin
            plan.f_rd        = 1'b1;
            plan.f_rd_addr   = f_last;
            plan.b_wr        = 1'b1;
            plan.b_wr_addr   = b_prev;
            plan.b_wr_moved  = 1'b1;
            back_start_next  = b_prev;
            back_count_next  = back_count + fmbq_pkg::HCNT_W'(1);
          end else begin
            front_count_next = front_count + fmbq_pkg::HCNT_W'(1);
          end
          plan.f_wr = 1'b1;
          if (operation == fmbq_pkg::OP_PUSH_FRONT) begin
            plan.f_wr_addr   = f_prev;
            front_start_next = f_prev;
          end else begin
            plan.f_wr_addr   = front_heavy ? f_last : f_tail;
          end
        end
      end
      fmbq_pkg::OP_POP_FRONT,
      fmbq_pkg::OP_POP_MIDDLE: begin
        if (total == '0) begin
          plan.status = fmbq_pkg::ST_EMPTY;
        end else begin
          plan.f_rd    = 1'b1;
          plan.pop_src = fmbq_pkg::POP_FRONT;
          if (operation == fmbq_pkg::OP_POP_FRONT) begin
            plan.f_rd_addr   = front_start;
            front_start_next = f_next;
          end else begin
            plan.f_rd_addr   = f_last;
          end
          // refill the front tail from the back head when it falls short
          if (!front_heavy && back_count != '0) begin
            plan.b_rd       = 1'b1;
            plan.b_rd_addr  = back_start;
            plan.f_wr       = 1'b1;
            plan.f_wr_addr  = (operation == fmbq_pkg::OP_POP_FRONT) ? f_tail : f_last;
            plan.f_wr_moved = 1'b1;
            back_start_next = b_next;
            back_count_next = back_count - fmbq_pkg::HCNT_W'(1);
          end else begin
            front_count_next = front_count - fmbq_pkg::HCNT_W'(1);
          end
        end
      end
      fmbq_pkg::OP_POP_BACK: begin
        if (total == '0) begin
          plan.status = fmbq_pkg::ST_EMPTY;
        end else if (back_count == '0) begin
          plan.f_rd        = 1'b1;
          plan.f_rd_addr   = f_last;
          plan.pop_src     = fmbq_pkg::POP_FRONT;
          front_count_next = front_count - fmbq_pkg::HCNT_W'(1);
        end else begin
          plan.b_rd      = 1'b1;
          plan.b_rd_addr = b_last;
          plan.pop_src   = fmbq_pkg::POP_BACK;
          if (front_heavy) begin
            // front now two ahead: hand its last element to the back head
            plan.f_rd        = 1'b1;
            plan.f_rd_addr   = f_last;
            plan.b_wr        = 1'b1;
            plan.b_wr_addr   = b_prev;
            plan.b_wr_moved  = 1'b1;
            back_start_next  = b_prev;
            front_count_next = front_count - fmbq_pkg::HCNT_W'(1);
          end else begin
            back_count_next  = back_count - fmbq_pkg::HCNT_W'(1);
          end
        end
      end
      default: begin
        // unused codes leave the queue as is
      end
    endcase

    total_next = fmbq_pkg::TOT_W'(front_count_next) + fmbq_pkg::TOT_W'(back_count_next);
    plan.count = fmbq_pkg::COUNT_W'(total_next);
  end

  // Pointer and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      front_start <= '0;
      back_start  <= '0;
      front_count <= '0;
      back_count  <= '0;
    end else if (take) begin
      front_start <= front_start_next;
      back_start  <= back_start_next;
      front_count <= front_count_next;
      back_count  <= back_count_next;
    end
  end

  // Front half holds the ceiling of half the elements
  a_balance: assert property (@(posedge clk) disable iff (rst)
    (front_count == back_count) || (front_count == back_count + fmbq_pkg::HCNT_W'(1)))
    else $error("fmbq_ctrl: halves out of balance");

  // Accepted transaction moves the total by at most one
  a_step: assert property (@(posedge clk) disable iff (rst)
    take |=> (total == $past(total)) || (total == $past(total) + fmbq_pkg::TOT_W'(1))
             || (total + fmbq_pkg::TOT_W'(1) == $past(total)))
    else $error("fmbq_ctrl: total changed by more than one");

  // Total never exceeds the capacity
  a_cap: assert property (@(posedge clk) disable iff (rst)
    total <= fmbq_pkg::TOT_W'(fmbq_pkg::CAPACITY))
    else $error("fmbq_ctrl: total above capacity");

endmodule

`default_nettype wire

>>> rtl/core/front_middle_back_queue_core.sv
// ----------------------------------------------------------------------------
// front_middle_back_queue_core
// Bounded queue with push and pop at the front, the middle and the back,
// kept as two ring-buffer halves in two synchronous RAMs.
// ----------------------------------------------------------------------------
// Each transaction is accepted in the idle state, where the accept edge reads
// the half RAMs at the addresses decoded from the ring pointers; the write-back
// state then writes back the pushed value, if any, and any element that moves
// across the boundary, and loads the result register. The write-back state waits
// while an earlier result is still stalled in the result register; the input side is
// stalled during write-back. The RAMs need no clearing after reset.
`default_nettype none

module front_middle_back_queue_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [fmbq_pkg::OP_W-1:0]          operation,
  input  wire logic signed [fmbq_pkg::DATA_W-1:0] value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [fmbq_pkg::DATA_W-1:0]      popped_value,
  output logic [1:0]                              status,
  output logic [fmbq_pkg::COUNT_W-1:0]            element_count
);

  fmbq_pkg::state_t state, state_next;
  fmbq_pkg::plan_t  plan;
  fmbq_pkg::plan_t  plan_q;
  logic             take;
  logic             finish;
  logic [fmbq_pkg::DATA_W-1:0] held_value;
  logic [fmbq_pkg::DATA_W-1:0] f_q, b_q;
  logic [fmbq_pkg::DATA_W-1:0] f_wr_data, b_wr_data;

  // Pointer control and access decode
  fmbq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .operation (operation),
    .plan      (plan)
  );

  // Front half store
  fmbq_ram #(
    .DEPTH (fmbq_pkg::HALF_DEPTH),
    .WIDTH (fmbq_pkg::DATA_W)
  ) u_front_ram (
    .clk     (clk),
    .wr_en   (finish && plan_q.f_wr),
    .wr_addr (plan_q.f_wr_addr),
    .wr_data (f_wr_data),
    .rd_en   (take && plan.f_rd),
    .rd_addr (plan.f_rd_addr),
    .rd_data (f_q)
  );

  // Back half store
  fmbq_ram #(
    .DEPTH (fmbq_pkg::HALF_DEPTH),
    .WIDTH (fmbq_pkg::DATA_W)
  ) u_back_ram (
    .clk     (clk),
    .wr_en   (finish && plan_q.b_wr),
    .wr_addr (plan_q.b_wr_addr),
    .wr_data (b_wr_data),
    .rd_en   (take && plan.b_rd),
    .rd_addr (plan.b_rd_addr),
    .rd_data (b_q)
  );

  // Write data: pushed value or the element crossing the boundary
  assign f_wr_data = plan_q.f_wr_moved ? b_q : held_value;
  assign b_wr_data = plan_q.b_wr_moved ? f_q : held_value;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmbq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    take       = 1'b0;
    finish     = 1'b0;
    unique case (state)
      fmbq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        take     = in_valid;
        if (in_valid) begin
          state_next = fmbq_pkg::S_WRITE;
        end
      end
      fmbq_pkg::S_WRITE: begin
        finish = !out_valid || !out_stall;
        if (finish) begin
          state_next = fmbq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fmbq_pkg::S_IDLE;
      end
    endcase
  end

  // Hold the plan and the pushed value for write-back
  always_ff @(posedge clk) begin
    if (take) begin
      plan_q     <= plan;
      held_value <= value;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status        <= plan_q.status;
      element_count <= plan_q.count;
      case (plan_q.pop_src)
        fmbq_pkg::POP_FRONT: popped_value <= f_q;
        fmbq_pkg::POP_BACK:  popped_value <= b_q;
        default:             popped_value <= '0;
      endcase
    end
  end

  // Accepted transaction always enters write-back
  a_take_write: assert property (@(posedge clk) disable iff (rst)
    take |=> state == fmbq_pkg::S_WRITE)
    else $error("front_middle_back_queue_core: no write-back after accept");

  // A new result appears only out of write-back
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == fmbq_pkg::S_WRITE))
    else $error("front_middle_back_queue_core: result without write-back");

  // Failed operations return no element
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == fmbq_pkg::ST_EMPTY || status == fmbq_pkg::ST_FULL))
      |-> popped_value == '0)
    else $error("front_middle_back_queue_core: failed operation returned data");

  // A dropped push reports a full queue
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == fmbq_pkg::ST_FULL)
      |-> element_count == fmbq_pkg::COUNT_W'(fmbq_pkg::CAPACITY))
    else $error("front_middle_back_queue_core: full status with wrong count");

endmodule

`default_nettype wire

>>> tb/sv/front_middle_back_queue_core_tb.sv
// ----------------------------------------------------------------------------
// front_middle_back_queue_core_tb
// Self-checking bench for the front/middle/back queue core. An internal
// two-half queue predicts popped value, status and element count for every
// accepted transaction. Directed cases cover empty pops, single-element pop
// back and no-op codes. Random phases then fill the queue to capacity under
// several idle and stall mixes, including a long result hold-off.
// ----------------------------------------------------------------------------
module front_middle_back_queue_core_tb;

  // Unused operation codes, treated as no-ops by the block
  localparam logic [fmbq_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [fmbq_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [fmbq_pkg::OP_W-1:0]          op;
    logic signed [fmbq_pkg::DATA_W-1:0] v;
  } request_t;

  typedef struct packed {
    logic signed [fmbq_pkg::DATA_W-1:0] popped;
    logic [1:0]                         status;
    logic [fmbq_pkg::COUNT_W-1:0]       count;
  } queue_result_t;

  logic                               clk;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [fmbq_pkg::OP_W-1:0]          operation = '0;
  logic signed [fmbq_pkg::DATA_W-1:0] value = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [fmbq_pkg::DATA_W-1:0] popped_value;
  logic [1:0]                         status;
  logic [fmbq_pkg::COUNT_W-1:0]       element_count;

  front_middle_back_queue_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .popped_value (popped_value),
    .status       (status),
    .element_count(element_count)
  );

  // Predicted queue contents, split as the block splits them
  logic signed [fmbq_pkg::DATA_W-1:0] front_half[$];
  logic signed [fmbq_pkg::DATA_W-1:0] back_half[$];

  request_t      pending_requests[$];
  queue_result_t expected_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  logic in_accepted  = 1'b0;

  int issued_total   = 0;
  int accepted_total = 0;
  int checked_total  = 0;
  int mismatches     = 0;
  int gen_count      = 0;
  int full_pushes    = 0;
  int empty_pops     = 0;
  int peak_count     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAIL front_middle_back_queue_core");
    $finish;
  end

  // Apply one operation to the predicted queue and return its result
  function automatic queue_result_t apply_queue_op(
      input logic [fmbq_pkg::OP_W-1:0] op,
      input logic signed [fmbq_pkg::DATA_W-1:0] v);
    queue_result_t r;
    int total;
    logic signed [fmbq_pkg::DATA_W-1:0] moved;
    r = '0;
    r.status = fmbq_pkg::ST_OK;
    total = front_half.size() + back_half.size();
    if (op <= fmbq_pkg::OP_PUSH_BACK) begin
      if (total >= fmbq_pkg::CAPACITY) begin
        r.status = fmbq_pkg::ST_FULL;
      end else if (op == fmbq_pkg::OP_PUSH_BACK) begin
        if (front_half.size() == back_half.size()) begin
          if (back_half.size() == 0) begin
            front_half.insert(front_half.size(), v);
          end else begin
            moved = back_half[0];
            back_half.delete(0);
            front_half.insert(front_half.size(), moved);
            back_half.insert(back_half.size(), v);
          end
        end else begin
          back_half.insert(back_half.size(), v);
        end
      end else begin
        // shift the front tail over before inserting at front or middle
        if (front_half.size() > back_half.size()) begin
          moved = front_half[$];
          front_half.delete(front_half.size() - 1);
          back_half.insert(0, moved);
        end
        if (op == fmbq_pkg::OP_PUSH_FRONT) front_half.insert(0, v);
        else front_half.insert(front_half.size(), v);
      end
    end else if (op <= fmbq_pkg::OP_POP_BACK) begin
      if (total == 0) begin
        r.status = fmbq_pkg::ST_EMPTY;
      end else if (op == fmbq_pkg::OP_POP_BACK) begin
        if (back_half.size() == 0) begin
          r.popped = front_half[$];
          front_half.delete(front_half.size() - 1);
        end else begin
          r.popped = back_half[$];
          back_half.delete(back_half.size() - 1);
          if (front_half.size() >= back_half.size() + 2) begin
            moved = front_half[$];
            front_half.delete(front_half.size() - 1);
            back_half.insert(0, moved);
          end
        end
      end else begin
        if (op == fmbq_pkg::OP_POP_FRONT) begin
          r.popped = front_half[0];
          front_half.delete(0);
        end else begin
          r.popped = front_half[$];
          front_half.delete(front_half.size() - 1);
        end
        // refill the front half if it fell short
        if (front_half.size() < back_half.size()) begin
          moved = back_half[0];
          back_half.delete(0);
          front_half.insert(front_half.size(), moved);
        end
      end
    end
    r.count = fmbq_pkg::COUNT_W'(front_half.size() + back_half.size());
    return r;
  endfunction

  task automatic enqueue_request(input logic [fmbq_pkg::OP_W-1:0] op,
                                 input logic signed [fmbq_pkg::DATA_W-1:0] v);
    request_t req;
    req.op = op;
    req.v  = v;
    pending_requests.insert(pending_requests.size(), req);
    issued_total++;
    if (op <= fmbq_pkg::OP_PUSH_BACK) begin
      if (gen_count < fmbq_pkg::CAPACITY) gen_count++;
    end else if (op <= fmbq_pkg::OP_POP_BACK) begin
      if (gen_count > 0) gen_count--;
    end
  endtask

  // Queue random transactions; with to_full, run until the queue is full
  task automatic add_random(input int n, input int push_pct, input bit to_full);
    int k;
    logic [fmbq_pkg::OP_W-1:0] op;
    logic signed [fmbq_pkg::DATA_W-1:0] v;
    k = 0;
    while (to_full ? (gen_count < fmbq_pkg::CAPACITY) : (k < n)) begin
      if ($urandom_range(0, 99) < 3) begin
        op = $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;
      end else if ($urandom_range(0, 99) < push_pct) begin
        op = fmbq_pkg::OP_W'($urandom_range(fmbq_pkg::OP_PUSH_FRONT,
                                            fmbq_pkg::OP_PUSH_BACK));
      end else begin
        op = fmbq_pkg::OP_W'($urandom_range(fmbq_pkg::OP_POP_FRONT,
                                            fmbq_pkg::OP_POP_BACK));
      end
      case ($urandom_range(0, 15))
        0:       v = 32'sh8000_0000;
        1:       v = 32'sh7fff_ffff;
        2:       v = -32'sd1;
        default: v = $urandom;
      endcase
      enqueue_request(op, v);
      k++;
    end
  endtask

  // Hold the sender until every queued transaction has its result
  task automatic wait_drained();
    while (checked_total != issued_total) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Input driver: hold a transaction until taken, then offer the next or idle
  always @(negedge clk) begin : drive_input
    request_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_accepted)) begin
      if (pending_requests.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        req = pending_requests[0];
        pending_requests.delete(0);
        in_valid  <= 1'b1;
        operation <= req.op;
        value     <= req.v;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall: long hold-off on request, random stalls otherwise
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: predict on input transactions, check result transactions
  always @(posedge clk) begin : monitor
    queue_result_t want;
    if (rst) begin
      in_accepted <= 1'b0;
    end else begin
      in_accepted <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        want = apply_queue_op(operation, value);
        expected_results.insert(expected_results.size(), want);
        accepted_total++;
        if (want.status == fmbq_pkg::ST_FULL) full_pushes++;
        if (want.status == fmbq_pkg::ST_EMPTY) empty_pops++;
        if (int'(want.count) > peak_count) peak_count = int'(want.count);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] result with nothing expected: value %0d status %0d count %0d",
                     $realtime, popped_value, status, element_count);
          end
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          checked_total++;
          if (popped_value !== want.popped || status !== want.status ||
              element_count !== want.count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("[%0t] result %0d: value %0d/%0d status %0d/%0d count %0d/%0d (exp/act)",
                       $realtime, checked_total, want.popped, popped_value,
                       want.status, status, want.count, element_count);
            end
          end
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty pops, no-ops, single-element pop back, value extremes
    enqueue_request(fmbq_pkg::OP_POP_FRONT, 32'sd5);
    enqueue_request(fmbq_pkg::OP_POP_MIDDLE, -32'sd1);
    enqueue_request(fmbq_pkg::OP_POP_BACK, 32'sd0);
    enqueue_request(OP_UNUSED_LO, 32'sd9);
    enqueue_request(OP_UNUSED_HI, -32'sd9);
    enqueue_request(fmbq_pkg::OP_PUSH_BACK, 32'sh7fff_ffff);
    enqueue_request(fmbq_pkg::OP_POP_BACK, 32'sd0);
    enqueue_request(fmbq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
    enqueue_request(fmbq_pkg::OP_PUSH_MIDDLE, -32'sd1);
    enqueue_request(fmbq_pkg::OP_PUSH_BACK, 32'sd0);
    enqueue_request(fmbq_pkg::OP_PUSH_BACK, 32'sh5555_aaaa);
    enqueue_request(fmbq_pkg::OP_PUSH_FRONT, 32'shaaaa_5555);
    enqueue_request(fmbq_pkg::OP_PUSH_MIDDLE, 32'sd1);
    enqueue_request(OP_UNUSED_HI, 32'sd0);
    enqueue_request(fmbq_pkg::OP_POP_MIDDLE, 32'sd0);
    enqueue_request(fmbq_pkg::OP_POP_FRONT, 32'sd0);
    enqueue_request(fmbq_pkg::OP_POP_BACK, 32'sd0);
    enqueue_request(OP_UNUSED_LO, 32'sd0);
    enqueue_request(fmbq_pkg::OP_POP_MIDDLE, 32'sd0);
    enqueue_request(fmbq_pkg::OP_POP_BACK, 32'sd0);
    enqueue_request(fmbq_pkg::OP_POP_FRONT, 32'sd0);
    enqueue_request(fmbq_pkg::OP_POP_BACK, 32'sd0);
    enqueue_request(fmbq_pkg::OP_POP_MIDDLE, 32'sd0);
    wait_drained();

    // Random near empty, no idling, with a long result hold-off
    set_idling(0, 0);
    add_random(80, 60, 1'b0);
    hold_req++;
    wait_drained();

    // Grow the queue with a mostly idle sender
    set_idling(79, 0);
    add_random(250, 100, 1'b0);
    wait_drained();

    // Fill to capacity against a mostly stalled receiver
    set_idling(0, 79);
    add_random(0, 100, 1'b1);
    wait_drained();

    // Work around full, both sides idling
    set_idling(25, 25);
    add_random(40, 50, 1'b0);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d transactions and %0d results: %0d full pushes, %0d empty pops,",
             accepted_total, checked_total, full_pushes, empty_pops);
    $display("peak occupancy %0d of %0d, %0d mismatches.", peak_count,
             fmbq_pkg::CAPACITY, mismatches);
    if (mismatches == 0) begin
      $display("PASS front_middle_back_queue_core");
    end else begin
      $display("FAIL front_middle_back_queue_core");
    end
    $finish;
  end

endmodule
